// ----- rtl/irrpr_pkg.sv -----
// ----------------------------------------------------------------------------
// irrpr_pkg
// Types, codes and constants shared by the IR remote press/repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

package irrpr_pkg;

   localparam logic [7:0]  OWN_BUS              = 8'd0;
   localparam logic [7:0]  PRESS_CHANNEL        = 8'd0;
   localparam logic [7:0]  LAST_RX_CHANNEL      = 8'd1;
   localparam int          MAX_REPEATS_PER_TICK = 63;
   localparam int          TICK_CNT_W           = 6;

   localparam logic [19:0] PERIOD_RESET  = 20'd108000;
   localparam logic [7:0]  PRESS_MIN_LEN = 8'd3;
   localparam logic [7:0]  READ_MIN_LEN  = 8'd2;
   localparam logic [15:0] CODE_BITS     = 16'd16;
   localparam logic [1:0]  READ_LEN      = 2'd2;

   localparam int REQ_DATA_W  = 128;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 168;
   localparam int RSP_USER_W  = 3;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_FRAME   = 2'd2,
      OP_ADVANCE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      FK_CODE    = 2'd0,
      FK_REPEAT  = 2'd1,
      FK_UNKNOWN = 2'd2,
      FK_SPARE   = 2'd3
   } frame_kind_type;

   typedef enum logic [2:0] {
      RK_WRITE_STATUS = 3'd0,
      RK_READ_REPLY   = 3'd1,
      RK_FRAME_DONE   = 3'd2,
      RK_CODE_SENT    = 3'd3,
      RK_REPEAT_SENT  = 3'd4,
      RK_ADVANCE_DONE = 3'd5
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PRESS_ADD,
      ST_STATUS,
      ST_TICK_CMP,
      ST_TICK_STEP,
      ST_DONE
   } state_type;

   // operands of the shared 64-bit adder
   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic        cin;
   } alu_req_type;

   typedef struct packed {
      logic [63:0] sum;
      logic        cout;
   } alu_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/irrpr_alu.sv -----
// ----------------------------------------------------------------------------
// irrpr_alu
// Shared 64-bit adder: schedule additions and the due-time compare
// (a + ~b + 1, carry out set when a >= b).
// ----------------------------------------------------------------------------
`default_nettype none

module irrpr_alu (
   input  irrpr_pkg::alu_req_type req,
   output irrpr_pkg::alu_rsp_type rsp
);
   import irrpr_pkg::*;

   logic [64:0] total;

   assign total    = {1'b0, req.a} + {1'b0, req.b} + {64'd0, req.cin};
   assign rsp.sum  = total[63:0];
   assign rsp.cout = total[64];

endmodule

`default_nettype wire

// ----- rtl/ir_remote_press_repeat_unit.sv -----
// ----------------------------------------------------------------------------
// ir_remote_press_repeat_unit
// Frame-level IR remote: press writes, last-received reads, received frames
// and time advances that send due repeat frames through one shared adder.
// ----------------------------------------------------------------------------
//  channel  | direction | words
//  req_*    | in        | one operation per word
//  rsp_*    | out       | 1..64 result words per operation, tlast on the final
//  csr_*    | in        | repeat period write, no read-back
//
//  A press with repeats takes an extra adder step for the due time; a time
//  advance takes a compare, then an add, for each repeat frame sent.
//  Reset: synchronous; period to 108000 us, all else but latched data to zero.
//  req_tready is high only in idle; a held rsp word stalls the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_press_repeat_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // channel[7:0] length[15:8] byte_zero[23:16] byte_one[31:24]
   // repeat_request[39:32] bus_number[47:40] frame_bits[63:48] now_us[127:64]
   input  wire  [irrpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation[1:0] frame_kind[3:2]
   input  wire  [irrpr_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // accepted[0] tx_address[8:1] tx_command[16:9] rx_address[24:17]
   // rx_command[32:25] reply_length[34:33] sent_total[66:35]
   // received_total[98:67] key_held[99] wake_time_us[163:100] zero[167:164]
   output logic [irrpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // result_kind[2:0]
   output logic [irrpr_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire                                  csr_wen,
   input  wire  [19:0]                          csr_wdata
);
   import irrpr_pkg::*;

   state_type       state_ff, state_in;
   logic [19:0]     period_ff;

   logic            holding_ff, holding_in;
   logic [7:0]      repeats_ff, repeats_in;
   logic [63:0]     due_ff, due_in;
   logic [7:0]      press_addr_ff, press_addr_in;
   logic [7:0]      press_cmd_ff, press_cmd_in;
   logic [7:0]      rx_addr_ff, rx_addr_in;
   logic [7:0]      rx_cmd_ff, rx_cmd_in;
   logic [31:0]     sent_ff, sent_in;
   logic [31:0]     recv_ff, recv_in;
   logic [TICK_CNT_W-1:0] tick_cnt_ff, tick_cnt_in;

   // latched operation
   op_type          op_ff;
   frame_kind_type  fkind_ff;
   logic [7:0]      chan_ff, len_ff, b0_ff, b1_ff, rep_ff, bus_ff;
   logic [15:0]     fbits_ff;
   logic [63:0]     now_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]      rsp_user_ff, rsp_user_in;
   logic                       rsp_last_ff, rsp_last_in;

   alu_req_type     alu_req;
   alu_rsp_type     alu_rsp;

   logic            out_free;
   logic            emit;
   result_kind_type o_kind;
   logic            o_acc, o_last;
   logic [7:0]      o_txa, o_txc, o_rxa, o_rxc;
   logic [1:0]      o_rlen;
   logic            press_ok, read_ok;

   irrpr_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign press_ok   = (chan_ff == PRESS_CHANNEL) && (len_ff >= PRESS_MIN_LEN);
   assign read_ok    = (chan_ff == LAST_RX_CHANNEL) && (len_ff >= READ_MIN_LEN);

   always_comb begin
      state_in      = state_ff;
      holding_in    = holding_ff;
      repeats_in    = repeats_ff;
      due_in        = due_ff;
      press_addr_in = press_addr_ff;
      press_cmd_in  = press_cmd_ff;
      rx_addr_in    = rx_addr_ff;
      rx_cmd_in     = rx_cmd_ff;
      sent_in       = sent_ff;
      recv_in       = recv_ff;
      tick_cnt_in   = tick_cnt_ff;
      alu_req.a     = now_ff;
      alu_req.b     = {44'd0, period_ff};
      alu_req.cin   = 1'b0;
      emit          = 1'b0;
      o_kind        = RK_WRITE_STATUS;
      o_acc         = 1'b0;
      o_last        = 1'b0;
      o_txa         = 8'd0;
      o_txc         = 8'd0;
      o_rxa         = 8'd0;
      o_rxc         = 8'd0;
      o_rlen        = 2'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            tick_cnt_in = '0;
            if (out_free) begin
               unique case (op_ff)
                  OP_WRITE: begin
                     emit = 1'b1;
                     if (press_ok) begin
                        press_addr_in = b0_ff;
                        press_cmd_in  = b1_ff;
                        sent_in       = sent_ff + 32'd1;
                        repeats_in    = rep_ff;
                        o_kind        = RK_CODE_SENT;
                        o_txa         = b0_ff;
                        o_txc         = b1_ff;
                        state_in      = (rep_ff != 8'd0) ? ST_PRESS_ADD : ST_STATUS;
                     end else begin
                        o_last   = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  OP_READ: begin
                     emit     = 1'b1;
                     o_kind   = RK_READ_REPLY;
                     o_last   = 1'b1;
                     if (read_ok) begin
                        o_acc  = 1'b1;
                        o_rxa  = rx_addr_ff;
                        o_rxc  = rx_cmd_ff;
                        o_rlen = READ_LEN;
                     end
                     state_in = ST_IDLE;
                  end
                  OP_FRAME: begin
                     if (bus_ff == OWN_BUS) begin
                        if (fkind_ff == FK_REPEAT && fbits_ff == 16'd0) begin
                           recv_in = recv_ff + 32'd1;
                        end else if (fkind_ff == FK_CODE && fbits_ff == CODE_BITS) begin
                           rx_addr_in = b0_ff;
                           rx_cmd_in  = b1_ff;
                           recv_in    = recv_ff + 32'd1;
                        end
                     end
                     emit     = 1'b1;
                     o_kind   = RK_FRAME_DONE;
                     o_last   = 1'b1;
                     state_in = ST_IDLE;
                  end
                  OP_ADVANCE: begin
                     state_in = ST_TICK_CMP;
                  end
               endcase
            end
         end
         ST_PRESS_ADD: begin
            repeats_in = repeats_ff - 8'd1;
            holding_in = 1'b1;
            due_in     = alu_rsp.sum;
            state_in   = ST_STATUS;
         end
         ST_STATUS: begin
            if (out_free) begin
               emit     = 1'b1;
               o_acc    = 1'b1;
               o_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TICK_CMP: begin
            alu_req.a   = now_ff;
            alu_req.b   = ~due_ff;
            alu_req.cin = 1'b1;
            if (tick_cnt_ff != TICK_CNT_W'(MAX_REPEATS_PER_TICK) && holding_ff
                && alu_rsp.cout) begin
               state_in = ST_TICK_STEP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TICK_STEP: begin
            alu_req.a = due_ff;
            if (out_free) begin
               tick_cnt_in = tick_cnt_ff + TICK_CNT_W'(1);
               sent_in     = sent_ff + 32'd1;
               if (repeats_ff == 8'd0) begin
                  holding_in = 1'b0;
               end else begin
                  repeats_in = repeats_ff - 8'd1;
                  due_in     = alu_rsp.sum;
               end
               emit     = 1'b1;
               o_kind   = RK_REPEAT_SENT;
               state_in = ST_TICK_CMP;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               o_kind   = RK_ADVANCE_DONE;
               o_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result word carries state after this step's update
      rsp_data_in = {4'd0, due_in, holding_in, recv_in, sent_in, o_rlen,
                     o_rxc, o_rxa, o_txc, o_txa, o_acc};
      rsp_user_in = o_kind;
      rsp_last_in = o_last;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         period_ff     <= PERIOD_RESET;
         holding_ff    <= 1'b0;
         repeats_ff    <= 8'd0;
         due_ff        <= 64'd0;
         press_addr_ff <= 8'd0;
         press_cmd_ff  <= 8'd0;
         rx_addr_ff    <= 8'd0;
         rx_cmd_ff     <= 8'd0;
         sent_ff       <= 32'd0;
         recv_ff       <= 32'd0;
         tick_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         holding_ff    <= holding_in;
         repeats_ff    <= repeats_in;
         due_ff        <= due_in;
         press_addr_ff <= press_addr_in;
         press_cmd_ff  <= press_cmd_in;
         rx_addr_ff    <= rx_addr_in;
         rx_cmd_ff     <= rx_cmd_in;
         sent_ff       <= sent_in;
         recv_ff       <= recv_in;
         tick_cnt_ff   <= tick_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wen) begin
            period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= op_type'(req_tuser[1:0]);
         fkind_ff <= frame_kind_type'(req_tuser[3:2]);
         chan_ff  <= req_tdata[7:0];
         len_ff   <= req_tdata[15:8];
         b0_ff    <= req_tdata[23:16];
         b1_ff    <= req_tdata[31:24];
         rep_ff   <= req_tdata[39:32];
         bus_ff   <= req_tdata[47:40];
         fbits_ff <= req_tdata[63:48];
         now_ff   <= req_tdata[127:64];
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
